>>> hw/rtl/skt_pkg.sv
// Shared constants, types and status codes for the sorted unique key table.
package skt_pkg;

  // Number of key cells in the chain
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned STAT_W   = 3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STAT_W-1:0] ST_SCAN_ENTRY = 3'd3;
  localparam logic [STAT_W-1:0] ST_SCAN_EMPTY = 3'd4;

  // Input opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SCAN   = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [STAT_W-1:0]       stat_t;

  // Command broadcast from control to every cell
  typedef struct packed {
    logic insert;
    logic rotate;
    key_t key;
  } chain_ctl_t;

  // Summary of the chain seen by control
  typedef struct packed {
    logic dup;
    logic full;
    key_t head_key;
  } chain_sts_t;

endpackage

>>> hw/rtl/skt_if.sv
// Valid/ready channel interfaces for input items and result items.
interface skt_in_if;
  logic          valid;
  logic          ready;
  logic          opcode;
  skt_pkg::key_t key;

  modport source (output valid, opcode, key, input ready);
  modport sink   (input valid, opcode, key, output ready);
endinterface

interface skt_out_if;
  logic           valid;
  logic           ready;
  skt_pkg::stat_t status;
  skt_pkg::key_t  key_out;
  logic           last;

  modport source (output valid, status, key_out, last, input ready);
  modport sink   (input valid, status, key_out, last, output ready);
endinterface

>>> hw/rtl/sorted_unique_key_table.sv
// Top level of the sorted unique key table: a chain of key cells and its control.
//
//  channel | dir | fields                      | transfer when
//  in_i    | in  | opcode, key                 | in_i.valid && in_i.ready
//  out_o   | out | status, key_out, last       | out_o.valid && out_o.ready
//
// On an insert all cells compare in parallel and shift in place.
// A scan of n keys gives n results (one empty result when n is zero); the chain
// rotates one cell per emitted key, so it is back in order after the last one.
// Reset clears the cell valid bits and the entry count; key values are not reset.
// A stalled output holds the chain; no input is taken until the scan is delivered.
module sorted_unique_key_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_in_if.sink    in_i,
  skt_out_if.source out_o
);

  localparam int unsigned N = skt_pkg::CAPACITY;

  skt_pkg::chain_ctl_t ctl;
  skt_pkg::chain_sts_t sts;
  logic [N-1:0]        cell_valid;
  logic [N-1:0]        cell_after;
  logic [N-1:0]        cell_eq;
  skt_pkg::key_t       cell_key [N];

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic          lv, la, rv;
    skt_pkg::key_t lk, rk;
    if (i == 0) begin : g_first
      assign lv = 1'b0;
      assign la = 1'b0;
      assign lk = '0;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign la = cell_after[i-1];
      assign lk = cell_key[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rv = 1'b0;
      assign rk = '0;
    end else begin : g_inner
      assign rv = cell_valid[i+1];
      assign rk = cell_key[i+1];
    end
    skt_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .left_valid_i  (lv),
      .left_after_i  (la),
      .left_key_i    (lk),
      .right_valid_i (rv),
      .right_key_i   (rk),
      .head_key_i    (cell_key[0]),
      .valid_o       (cell_valid[i]),
      .after_o       (cell_after[i]),
      .eq_o          (cell_eq[i]),
      .key_o         (cell_key[i])
    );
  end

  // Chain summary for control
  always_comb begin
    sts.dup      = |cell_eq;
    sts.full     = cell_valid[N-1];
    sts.head_key = cell_key[0];
  end

  skt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_opcode_i  (in_i.opcode),
    .in_key_i     (in_i.key),
    .sts_i        (sts),
    .ctl_o        (ctl),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_key_o    (out_o.key_out),
    .out_last_o   (out_o.last)
  );

endmodule

>>> hw/rtl/skt_cell.sv
// One key cell of the sorted chain: holds a key, shifts right on insert, left on scan.
module skt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  skt_pkg::chain_ctl_t ctl_i,
  input  logic                left_valid_i,
  input  logic                left_after_i,
  input  skt_pkg::key_t       left_key_i,
  input  logic                right_valid_i,
  input  skt_pkg::key_t       right_key_i,
  input  skt_pkg::key_t       head_key_i,
  output logic                valid_o,
  output logic                after_o,
  output logic                eq_o,
  output skt_pkg::key_t       key_o
);

  logic          valid_q, valid_d;
  skt_pkg::key_t key_q, key_d;

  // Compare against the broadcast key; empty cells count as "after" the new key
  assign after_o = !valid_q || (key_q > ctl_i.key);
  assign eq_o    = valid_q && (key_q == ctl_i.key);
  assign valid_o = valid_q;
  assign key_o   = key_q;

  // Next state: shift in from the left, take the new key, or rotate toward the head
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (ctl_i.insert) begin
      if (left_after_i) begin
        valid_d = left_valid_i;
        key_d   = left_key_i;
      end else if (after_o) begin
        valid_d = 1'b1;
        key_d   = ctl_i.key;
      end
    end else if (ctl_i.rotate && valid_q) begin
      // last occupied cell wraps around to the head key
      key_d = right_valid_i ? right_key_i : head_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

>>> hw/rtl/skt_ctrl.sv
// Control: input handshake, entry count, scan sequencing and the result register.
module skt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_opcode_i,
  input  skt_pkg::key_t       in_key_i,
  input  skt_pkg::chain_sts_t sts_i,
  output skt_pkg::chain_ctl_t ctl_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output skt_pkg::stat_t      out_status_o,
  output skt_pkg::key_t       out_key_o,
  output logic                out_last_o
);

  typedef enum logic {
    IDLE,
    SCAN
  } state_e;

  state_e         state_q, state_d;
  skt_pkg::cnt_t  count_q, count_d;
  skt_pkg::cnt_t  rem_q, rem_d;
  skt_pkg::cnt_t  rem_eff;
  logic           out_valid_q, out_valid_d;
  skt_pkg::stat_t status_q, status_d;
  skt_pkg::key_t  key_q, key_d;
  logic           last_q, last_d;
  logic           out_free, acc, acc_ins, acc_scan, scan_emit;

  // Output register is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == IDLE) && out_free;
  assign acc        = in_valid_i && in_ready_o;
  assign acc_ins    = acc && (in_opcode_i == skt_pkg::OP_INSERT);
  assign acc_scan   = acc && (in_opcode_i == skt_pkg::OP_SCAN);

  // A scan emits its first entry on the transfer cycle, then one per free slot
  assign rem_eff   = (state_q == SCAN) ? rem_q : count_q;
  assign scan_emit = (acc_scan && (count_q != '0)) || ((state_q == SCAN) && out_free);

  // Chain command
  always_comb begin
    ctl_o.insert = acc_ins && !sts_i.dup && !sts_i.full;
    ctl_o.rotate = scan_emit;
    ctl_o.key    = in_key_i;
  end

  // Next-state and result logic
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    key_d       = key_q;
    last_d      = last_q;
    if (acc_ins) begin
      out_valid_d = 1'b1;
      key_d       = in_key_i;
      last_d      = 1'b1;
      if (sts_i.dup) begin
        status_d = skt_pkg::ST_DUPLICATE;
      end else if (sts_i.full) begin
        status_d = skt_pkg::ST_FULL;
      end else begin
        status_d = skt_pkg::ST_INSERTED;
        count_d  = skt_pkg::cnt_t'(count_q + 1'b1);
      end
    end else if (acc_scan && (count_q == '0)) begin
      out_valid_d = 1'b1;
      status_d    = skt_pkg::ST_SCAN_EMPTY;
      key_d       = '0;
      last_d      = 1'b1;
    end
    if (scan_emit) begin
      out_valid_d = 1'b1;
      status_d    = skt_pkg::ST_SCAN_ENTRY;
      key_d       = sts_i.head_key;
      last_d      = (rem_eff == skt_pkg::cnt_t'(1));
      rem_d       = skt_pkg::cnt_t'(rem_eff - 1'b1);
      state_d     = (rem_eff == skt_pkg::cnt_t'(1)) ? IDLE : SCAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      key_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      key_q       <= key_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_key_o    = key_q;
  assign out_last_o   = last_q;

endmodule

>>> hw/rtl/skt_checker.sv
// Port-level checker for the sorted unique key table, bound to the top level.
module skt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           in_opcode_i,
  input skt_pkg::key_t  in_key_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input skt_pkg::stat_t out_status_i,
  input skt_pkg::key_t  out_key_i,
  input logic           out_last_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_key_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // An insert answers in the next cycle with a single echoed result
  a_ins_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_opcode_i == skt_pkg::OP_INSERT) |=>
      out_valid_i && out_last_i && (out_key_i == $past(in_key_i)) &&
      ((out_status_i == skt_pkg::ST_INSERTED) || (out_status_i == skt_pkg::ST_DUPLICATE) ||
       (out_status_i == skt_pkg::ST_FULL)))
    else $error("insert result missing or malformed");

  // A scan starts its results in the next cycle
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_opcode_i == skt_pkg::OP_SCAN) |=>
      out_valid_i &&
      ((out_status_i == skt_pkg::ST_SCAN_ENTRY) || (out_status_i == skt_pkg::ST_SCAN_EMPTY)))
    else $error("scan result missing or malformed");

  // No new item while a scan is still being delivered
  a_scan_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input taken in the middle of a scan");

endmodule

bind sorted_unique_key_table skt_checker u_skt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .in_key_i     (in_i.key),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_key_i    (out_o.key_out),
  .out_last_i   (out_o.last)
);

>>> verif/sorted_unique_key_table_test.sv
// Self-checking testbench for the sorted unique key table: directed rows, then random traffic.
module sorted_unique_key_table_test;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 437;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One result transfer as seen on the output channel
  typedef struct packed {
    skt_pkg::stat_t status;
    skt_pkg::key_t  key_out;
    logic           last;
  } result_t;

  // One stimulus row; want is only used when typed is set
  typedef struct packed {
    logic          op;
    skt_pkg::key_t key;
    logic          typed;
    result_t       want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();

  sorted_unique_key_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the table contents
  skt_pkg::key_t table_keys [skt_pkg::CAPACITY];
  int unsigned   table_count;

  result_t   expected_results [$];
  result_t   step_results [$];
  stim_row_t directed_rows [$];

  // Row currently offered by the sender
  logic    cur_typed;
  result_t cur_want;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned taken_count;
  result_t     want_result;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Apply one item to the shadow table, leave its results in step_results
  function automatic void predict_table_step(input logic op, input skt_pkg::key_t k);
    int unsigned    pos;
    skt_pkg::stat_t st;
    step_results.delete();
    if (op == skt_pkg::OP_INSERT) begin
      pos = 0;
      while (pos < table_count && table_keys[pos] < k) pos++;
      if (pos < table_count && table_keys[pos] == k) begin
        st = skt_pkg::ST_DUPLICATE;
      end else if (table_count >= skt_pkg::CAPACITY) begin
        st = skt_pkg::ST_FULL;
      end else begin
        for (int i = table_count; i > pos; i--) table_keys[i] = table_keys[i-1];
        table_keys[pos] = k;
        table_count++;
        st = skt_pkg::ST_INSERTED;
      end
      step_results.push_back('{st, k, 1'b1});
    end else if (table_count == 0) begin
      step_results.push_back('{skt_pkg::ST_SCAN_EMPTY, '0, 1'b1});
    end else begin
      for (int i = 0; i < table_count; i++)
        step_results.push_back('{skt_pkg::ST_SCAN_ENTRY, table_keys[i],
                                 i == table_count - 1});
    end
  endfunction

  function automatic stim_row_t stim_row(input logic op, input skt_pkg::key_t k,
                                         input logic typed, input skt_pkg::stat_t st);
    stim_row_t r;
    r.op           = op;
    r.key          = k;
    r.typed        = typed;
    r.want.status  = st;
    r.want.key_out = (op == skt_pkg::OP_INSERT) ? k : '0;
    r.want.last    = 1'b1;
    return r;
  endfunction

  // Offer one item after a random gap, hold it until the transfer
  task automatic send_item(input stim_row_t row);
    int unsigned gap;
    gap = ((sent_count / 40) % 5 == 3) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.opcode = row.op;
    in_ch.key    = row.key;
    cur_typed    = row.typed;
    cur_want     = row.want;
    in_ch.valid  = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Check result transfers, then record what each accepted item should produce
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("sorted_unique_key_table: mismatch");
        $finish;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d key_out %0d last %0d",
                   out_ch.status, out_ch.key_out, out_ch.last);
            error_count++;
          end else begin
            want_result = expected_results.pop_front();
            if (out_ch.status !== want_result.status) begin
              $error("status: expected %0d, got %0d", want_result.status, out_ch.status);
              error_count++;
            end
            if (out_ch.key_out !== want_result.key_out) begin
              $error("key_out: expected %0d, got %0d", want_result.key_out, out_ch.key_out);
              error_count++;
            end
            if (out_ch.last !== want_result.last) begin
              $error("last: expected %0d, got %0d", want_result.last, out_ch.last);
              error_count++;
            end
          end
        end
        if (in_ch.valid && in_ch.ready) begin
          predict_table_step(in_ch.opcode, in_ch.key);
          if (cur_typed) begin
            expected_results.push_back(cur_want);
          end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
          end
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off, and quiet stretches
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    taken_count  = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (taken_count == 300) stall = 100;
      else if ((taken_count / 50) % 5 == 2) stall = 0;
      else stall = $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken_count++;
      @(negedge clk_i);
    end
  end

  // Reset, directed rows, random traffic, drain and verdict
  initial begin
    stim_row_t     row;
    int unsigned   pick;
    skt_pkg::key_t k;

    in_ch.valid  = 1'b0;
    in_ch.opcode = skt_pkg::OP_INSERT;
    in_ch.key    = '0;
    cur_typed    = 1'b0;
    cur_want     = '0;
    rst_ni       = 1'b0;
    table_count  = 0;
    cycle_count  = 0;
    error_count  = 0;
    sent_count   = 0;

    // Empty scan, extremes, duplicates, a scan, fill to capacity, full, duplicate-on-full, final scan
    directed_rows.push_back(
      stim_row(skt_pkg::OP_SCAN,   '0,            1'b1, skt_pkg::ST_SCAN_EMPTY));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sh7fffffff, 1'b1, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sh80000000, 1'b1, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, '0,            1'b1, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sh7fffffff, 1'b1, skt_pkg::ST_DUPLICATE));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sh80000000, 1'b1, skt_pkg::ST_DUPLICATE));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_SCAN,   '0,            1'b0, skt_pkg::ST_SCAN_ENTRY));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, -32'sd5,       1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sd5,        1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sd100,      1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, -32'sd100,     1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sd1,        1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, -32'sd1,       1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sh40000000, 1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'shc0000000, 1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sd2,        1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sd3,        1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sh7ffffffe, 1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sh80000001, 1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, -32'sd2,       1'b0, skt_pkg::ST_INSERTED));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, 32'sd7,        1'b1, skt_pkg::ST_FULL));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_INSERT, '0,            1'b1, skt_pkg::ST_DUPLICATE));
    directed_rows.push_back(
      stim_row(skt_pkg::OP_SCAN,   '0,            1'b0, skt_pkg::ST_SCAN_ENTRY));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Once, let the block drain completely before going on
      if (n == 150) begin
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk_i);
      end
      pick = $urandom_range(0, 99);
      k    = $urandom;
      if (pick >= 25 && table_count > 0)
        k = table_keys[$urandom_range(0, table_count - 1)];
      if (pick >= 60 && pick < 80)
        k = k + $signed($urandom_range(0, 4)) - 32'sd2;
      else if (pick >= 80)
        k = $urandom;
      row = stim_row((pick < 25) ? skt_pkg::OP_SCAN : skt_pkg::OP_INSERT, k, 1'b0,
                     skt_pkg::ST_INSERTED);
      send_item(row);
    end
    in_ch.valid = 1'b0;

    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("sorted_unique_key_table: match");
    end else begin
      $display("sorted_unique_key_table: mismatch");
    end
    $finish;
  end

endmodule
